>>> hw/rtl/dsp_pkg.sv
// Shared types, character constants and digit helpers for the declination
// string parser. No dependencies.
package dsp_pkg;

   // Parse phase of the current string
   typedef enum logic [2:0] {
      PH_SIGN = 3'd0,
      PH_DEG1 = 3'd1,
      PH_DEG2 = 3'd2,
      PH_STAR = 3'd3,
      PH_MIN  = 3'd4,
      PH_SEC  = 3'd5
   } phase_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FORMAT = 2'd1,
      ST_RANGE  = 2'd2
   } status_type;

   // ASCII codes
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Accumulator limits
   localparam logic [6:0] ACC_MAX = 7'd127;
   localparam logic [6:0] DEG_MAX = 7'd90;
   localparam logic [6:0] SEXA    = 7'd60;

   // One input word
   typedef struct packed {
      logic [7:0] char_code;
      logic       has_char;
      logic       last;
   } item_type;

   // One result word
   typedef struct packed {
      status_type status;
      logic       negative;
      logic [6:0] deg;
      logic [5:0] arcmin;
      logic [5:0] arcsec;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {[CH_ZERO:CH_NINE]});
   endfunction

   // acc * 10 + digit, saturating at 127; c must be an ASCII digit
   function automatic logic [6:0] acc_push(input logic [6:0] acc, input logic [7:0] c);
      logic [10:0] v;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {7'b0, c[3:0]};
      return (v > {4'b0, ACC_MAX}) ? ACC_MAX : v[6:0];
   endfunction

   // Digit counter, saturating at 3
   function automatic logic [1:0] count_up(input logic [1:0] n);
      return (n == 2'd3) ? 2'd3 : n + 2'd1;
   endfunction

endpackage

>>> hw/rtl/declination_string_parser_unit.sv
// Declination string parser, top level. Use:
//  - req_ channel: one word per character (char_code, has_char, last);
//    a word with has_char low and last high closes a string with no
//    further character. Accepted when req_valid is high and req_stall low.
//  - rsp_ channel: one result word per string, when its last word has gone
//    through: status, negative, deg_out, arcmin_out, arcsec_out. Fields
//    other than status read zero unless status is ok.
//  - csr_ channel: csr_high_precision selects sDD*MM:SS (1) or sDD*MM (0);
//    csr_ready is always high. Write it only between strings; the value
//    is sampled at the first character of each string.
// Throughput is one word per cycle while rsp_stall holds no result: each
// character is checked by one pass of logic between the input register
// and the parse state. A result is presented once its last word has gone
// through the input register and then loaded into the result register.
// Reset clears the parse state, empties both registers and sets high
// precision. While rsp_stall holds a result, one more word is still taken
// into the input register; req_stall rises only once that is full too.
// Depends on dsp_pkg, dsp_input_stage and dsp_parse_core.
module declination_string_parser_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_has_char,
   input  logic       req_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_high_precision,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic       rsp_negative,
   output logic [6:0] rsp_deg_out,
   output logic [5:0] rsp_arcmin_out,
   output logic [5:0] rsp_arcsec_out
);
   import dsp_pkg::*;

   logic       hp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   item_type   req_item;
   item_type   item;
   logic       item_fire;
   logic       advance;
   logic       res_valid;
   result_type res;

   assign req_item.char_code = req_char_code;
   assign req_item.has_char  = req_has_char;
   assign req_item.last      = req_last;

   // Pipeline moves when the result register is empty or being taken
   assign advance = ~rsp_valid_ff | ~rsp_stall;

   dsp_input_stage u_input (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (advance),
      .item_fire (item_fire),
      .item      (item)
   );

   dsp_parse_core u_core (
      .clock          (clock),
      .reset          (reset),
      .high_precision (hp_ff),
      .item_fire      (item_fire),
      .item           (item),
      .res_valid      (res_valid),
      .res            (res)
   );

   // Mode register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         hp_ff <= csr_high_precision;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_negative   = rsp_ff.negative;
   assign rsp_deg_out    = rsp_ff.deg;
   assign rsp_arcmin_out = rsp_ff.arcmin;
   assign rsp_arcsec_out = rsp_ff.arcsec;

endmodule

>>> hw/rtl/dsp_input_stage.sv
// Input register of the declination string parser: holds one word and
// drives req_stall. Depends on dsp_pkg.
module dsp_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dsp_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_fire,
   output dsp_pkg::item_type item
);
   import dsp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     load;

   // Stall only when a word is held and cannot move on
   assign req_stall = valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;
   assign item_fire = valid_ff & advance;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

endmodule

>>> hw/rtl/dsp_parse_core.sv
// Per-string parse state and the per-character checks; forms the result
// word when the last word of a string goes through. Depends on dsp_pkg.
module dsp_parse_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                high_precision,
   input  logic                item_fire,
   input  dsp_pkg::item_type   item,
   output logic                res_valid,
   output dsp_pkg::result_type res
);
   import dsp_pkg::*;

   logic       started_ff, started_in;
   logic       mode_ff, mode_in;
   phase_type  phase_ff, phase_in;
   logic       sign_ff, sign_in;
   logic [6:0] deg_ff, deg_in;
   logic [6:0] min_ff, min_in;
   logic [1:0] mdig_ff, mdig_in;
   logic [6:0] sec_ff, sec_in;
   logic [1:0] sdig_ff, sdig_in;
   status_type err_ff, err_in;

   logic       mode_eff;
   status_type st;
   logic [7:0] c;

   assign c         = item.char_code;
   // Mode is taken from the register at the first character of a string
   assign mode_eff  = started_ff ? mode_ff : high_precision;
   assign res_valid = item_fire & item.last;

   // Character update, final status, then clear at end of string
   always_comb begin
      started_in = started_ff;
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      sign_in    = sign_ff;
      deg_in     = deg_ff;
      min_in     = min_ff;
      mdig_in    = mdig_ff;
      sec_in     = sec_ff;
      sdig_in    = sdig_ff;
      err_in     = err_ff;
      st         = ST_FORMAT;
      res        = '0;

      if (item_fire && item.has_char) begin
         started_in = 1'b1;
         mode_in    = mode_eff;
         if (err_ff == ST_OK) begin
            case (phase_ff)
               PH_SIGN: begin
                  if (c == CH_PLUS || c == CH_MINUS) begin
                     sign_in  = (c == CH_MINUS);
                     phase_in = PH_DEG1;
                  end else begin
                     err_in = ST_FORMAT;
                  end
               end
               PH_DEG1, PH_DEG2: begin
                  if (is_digit(c)) begin
                     deg_in   = acc_push(deg_ff, c);
                     phase_in = (phase_ff == PH_DEG1) ? PH_DEG2 : PH_STAR;
                  end else begin
                     err_in = ST_FORMAT;
                  end
               end
               PH_STAR: begin
                  if (c != CH_STAR) begin
                     err_in = ST_FORMAT;
                  end else if (deg_ff > DEG_MAX) begin
                     err_in = ST_RANGE;
                  end else begin
                     phase_in = PH_MIN;
                  end
               end
               PH_MIN: begin
                  if (mode_eff && (c == CH_COLON || c == CH_APOS)) begin
                     if (mdig_ff == 2'd0) begin
                        err_in = ST_FORMAT;
                     end else if (min_ff >= SEXA) begin
                        err_in = ST_RANGE;
                     end else begin
                        phase_in = PH_SEC;
                     end
                  end else if (is_digit(c)) begin
                     min_in  = acc_push(min_ff, c);
                     mdig_in = count_up(mdig_ff);
                  end else begin
                     err_in = ST_FORMAT;
                  end
               end
               PH_SEC: begin
                  sdig_in = count_up(sdig_ff);
                  if (is_digit(c)) begin
                     sec_in = acc_push(sec_ff, c);
                  end else begin
                     err_in = ST_FORMAT;
                  end
               end
               default: begin
                  err_in = ST_FORMAT;
               end
            endcase
         end
      end

      // End-of-string checks, in order
      if (err_in != ST_OK) begin
         st = err_in;
      end else if (phase_in == PH_MIN) begin
         if (mode_in || mdig_in != 2'd2) begin
            st = ST_FORMAT;
         end else if (min_in >= SEXA) begin
            st = ST_RANGE;
         end else if (deg_in == DEG_MAX && min_in != 7'd0) begin
            st = ST_RANGE;
         end else begin
            st = ST_OK;
         end
      end else if (phase_in == PH_SEC) begin
         if (sdig_in != 2'd2) begin
            st = ST_FORMAT;
         end else if (sec_in >= SEXA) begin
            st = ST_RANGE;
         end else if (deg_in == DEG_MAX && (min_in != 7'd0 || sec_in != 7'd0)) begin
            st = ST_RANGE;
         end else begin
            st = ST_OK;
         end
      end

      res.status = st;
      if (st == ST_OK) begin
         res.negative = sign_in;
         res.deg      = deg_in;
         res.arcmin   = min_in[5:0];
         res.arcsec   = (phase_in == PH_SEC) ? sec_in[5:0] : 6'd0;
      end

      // Ready for a new string after every result
      if (item_fire && item.last) begin
         started_in = 1'b0;
         mode_in    = 1'b1;
         phase_in   = PH_SIGN;
         sign_in    = 1'b0;
         deg_in     = 7'd0;
         min_in     = 7'd0;
         mdig_in    = 2'd0;
         sec_in     = 7'd0;
         sdig_in    = 2'd0;
         err_in     = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         mode_ff    <= 1'b1;
         phase_ff   <= PH_SIGN;
         sign_ff    <= 1'b0;
         deg_ff     <= 7'd0;
         min_ff     <= 7'd0;
         mdig_ff    <= 2'd0;
         sec_ff     <= 7'd0;
         sdig_ff    <= 2'd0;
         err_ff     <= ST_OK;
      end else begin
         started_ff <= started_in;
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         sign_ff    <= sign_in;
         deg_ff     <= deg_in;
         min_ff     <= min_in;
         mdig_ff    <= mdig_in;
         sec_ff     <= sec_in;
         sdig_ff    <= sdig_in;
         err_ff     <= err_in;
      end
   end

endmodule

>>> hw/rtl/dsp_checker.sv
// Port-level checks for the declination string parser, bound to the top
// level. Depends on dsp_pkg and declination_string_parser_unit.
module dsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic       rsp_negative,
   input logic [6:0] rsp_deg_out,
   input logic [5:0] rsp_arcmin_out,
   input logic [5:0] rsp_arcsec_out
);
   import dsp_pkg::*;

   // No result word straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_negative) && $stable(rsp_deg_out)
         && $stable(rsp_arcmin_out) && $stable(rsp_arcsec_out))
      else $error("stalled result word changed");

   // A good result is within range, and 90 degrees carries no minutes or seconds
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_deg_out <= 7'd90
         && rsp_arcmin_out <= 6'd59 && rsp_arcsec_out <= 6'd59
         && (rsp_deg_out != 7'd90 || (rsp_arcmin_out == 6'd0 && rsp_arcsec_out == 6'd0)))
      else $error("good result out of range");

   // A failed result carries zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_negative && rsp_deg_out == 7'd0
         && rsp_arcmin_out == 6'd0 && rsp_arcsec_out == 6'd0)
      else $error("failed result with non-zero fields");

endmodule

bind declination_string_parser_unit dsp_checker u_dsp_checker (.*);

>>> test/declination_string_parser_unit_tb.sv
// Self-checking testbench for declination_string_parser_unit: a queue-fed driver,
// a monitor with random stalls and a built-in angle predictor.
// Depends on dsp_pkg and the declination_string_parser_unit RTL.
`timescale 1ns / 1ps

module declination_string_parser_unit_tb;
   import dsp_pkg::*;

   localparam int CLOSE_NONE     = 0;
   localparam int CLOSE_ON_CHAR  = 1;
   localparam int CLOSE_EMPTY    = 2;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int PHASE_WORDS    = 80;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code = 8'd0;
   logic       req_has_char = 1'b0;
   logic       req_last = 1'b0;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_high_precision = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic       rsp_negative;
   logic [6:0] rsp_deg_out;
   logic [5:0] rsp_arcmin_out;
   logic [5:0] rsp_arcsec_out;

   // Stimulus and checking state
   item_type   word_q[$];
   logic [7:0] text_buf[$];
   result_type parsed_angle_q[$];
   item_type   drive_word;
   int         in_flight = 0;
   int         items_queued = 0;
   int         fail_cnt = 0;
   int         gap_left = 0;
   int         stall_left = 0;
   int         quiet_cycles = 0;
   bit         drv_calm = 1'b0;
   bit         mon_calm = 1'b0;

   // Predictor state
   bit         cfg_hp = 1'b1;
   bit         mode_hp = 1'b1;
   logic [7:0] pos = 8'd0;
   phase_type  phase = PH_SIGN;
   bit         neg_sign = 1'b0;
   logic [6:0] deg_acc = 7'd0;
   logic [6:0] min_acc = 7'd0;
   logic [1:0] min_cnt = 2'd0;
   logic [6:0] sec_acc = 7'd0;
   logic [1:0] sec_cnt = 2'd0;
   status_type err = ST_OK;

   declination_string_parser_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .req_has_char       (req_has_char),
      .req_last           (req_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_high_precision (csr_high_precision),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_negative       (rsp_negative),
      .rsp_deg_out        (rsp_deg_out),
      .rsp_arcmin_out     (rsp_arcmin_out),
      .rsp_arcsec_out     (rsp_arcsec_out)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic bit is_decimal(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // Shift a decimal digit into an accumulator, clamped at 127
   function automatic logic [6:0] push_digit(input logic [6:0] acc, input logic [7:0] c);
      int v;
      v = int'(acc) * 10 + int'(c) - int'(CH_ZERO);
      return (v > 127) ? 7'd127 : v[6:0];
   endfunction

   function automatic logic [1:0] bump(input logic [1:0] n);
      return (n == 2'd3) ? 2'd3 : n + 2'd1;
   endfunction

   function automatic void clear_parse();
      pos      = 8'd0;
      phase    = PH_SIGN;
      neg_sign = 1'b0;
      deg_acc  = 7'd0;
      min_acc  = 7'd0;
      min_cnt  = 2'd0;
      sec_acc  = 7'd0;
      sec_cnt  = 2'd0;
      err      = ST_OK;
      mode_hp  = 1'b1;
   endfunction

   function automatic void take_char(input logic [7:0] c);
      case (phase)
         PH_SIGN: begin
            if (c == CH_PLUS || c == CH_MINUS) begin
               neg_sign = (c == CH_MINUS);
               phase = PH_DEG1;
            end else
               err = ST_FORMAT;
         end
         PH_DEG1, PH_DEG2: begin
            if (is_decimal(c)) begin
               deg_acc = push_digit(deg_acc, c);
               phase = phase_type'(phase + 1);
            end else
               err = ST_FORMAT;
         end
         PH_STAR: begin
            if (c != CH_STAR)
               err = ST_FORMAT;
            else if (deg_acc > DEG_MAX)
               err = ST_RANGE;
            else
               phase = PH_MIN;
         end
         PH_MIN: begin
            // separator only counts in the seconds form
            if (mode_hp && (c == CH_COLON || c == CH_APOS)) begin
               if (min_cnt == 2'd0)
                  err = ST_FORMAT;
               else if (min_acc >= SEXA)
                  err = ST_RANGE;
               else
                  phase = PH_SEC;
            end else if (is_decimal(c)) begin
               min_acc = push_digit(min_acc, c);
               min_cnt = bump(min_cnt);
            end else
               err = ST_FORMAT;
         end
         PH_SEC: begin
            sec_cnt = bump(sec_cnt);
            if (is_decimal(c))
               sec_acc = push_digit(sec_acc, c);
            else
               err = ST_FORMAT;
         end
         default: err = ST_FORMAT;
      endcase
   endfunction

   // Checks left over for the end of the string
   function automatic status_type closing_status();
      if (err != ST_OK)
         return err;
      if (phase == PH_MIN) begin
         if (mode_hp || min_cnt != 2'd2)
            return ST_FORMAT;
         if (min_acc >= SEXA)
            return ST_RANGE;
         if (deg_acc == DEG_MAX && min_acc != 7'd0)
            return ST_RANGE;
         return ST_OK;
      end
      if (phase == PH_SEC) begin
         if (sec_cnt != 2'd2)
            return ST_FORMAT;
         if (sec_acc >= SEXA)
            return ST_RANGE;
         if (deg_acc == DEG_MAX && (min_acc != 7'd0 || sec_acc != 7'd0))
            return ST_RANGE;
         return ST_OK;
      end
      return ST_FORMAT;
   endfunction

   // Advance the parse by one accepted word; a closing word queues the expected angle
   function automatic void decl_parse_word(input item_type w);
      result_type r;
      if (w.has_char) begin
         if (pos == 8'd0)
            mode_hp = cfg_hp;
         if (err == ST_OK)
            take_char(w.char_code);
         if (pos != 8'hFF)
            pos = pos + 8'd1;
      end
      if (w.last) begin
         r = '0;
         r.status = closing_status();
         if (r.status == ST_OK) begin
            r.negative = neg_sign;
            r.deg      = deg_acc;
            r.arcmin   = min_acc[5:0];
            r.arcsec   = (phase == PH_SEC) ? sec_acc[5:0] : 6'd0;
         end
         parsed_angle_q.push_back(r);
         clear_parse();
      end
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 8'(CH_ZERO + $urandom_range(0, 9));
         4:          return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
         5:          return CH_STAR;
         6:          return $urandom_range(0, 1) ? CH_COLON : CH_APOS;
         7:          return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      text_buf.push_back(b);
   endfunction

   function automatic void put_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text_buf.push_back(s[i]);
   endfunction

   // n decimal digits of v, leading zeros kept
   function automatic void put_digits(input int v, input int n);
      int div;
      div = 1;
      repeat (n - 1) div *= 10;
      repeat (n) begin
         put_byte(8'(int'(CH_ZERO) + (v / div) % 10));
         div /= 10;
      end
   endfunction

   // Turn the text buffer into words, with optional ignored words mixed in
   function automatic void flush_text(input int close_how, input bit noisy);
      item_type w;
      int       n;
      n = text_buf.size();
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 7) == 0) begin
            w.char_code = 8'($urandom_range(0, 255));
            w.has_char  = 1'b0;
            w.last      = 1'b0;
            word_q.push_back(w);
            in_flight++;
         end
         w.char_code = text_buf[i];
         w.has_char  = 1'b1;
         w.last      = (i == n - 1) && (close_how == CLOSE_ON_CHAR);
         word_q.push_back(w);
         in_flight++;
         items_queued++;
      end
      if (close_how == CLOSE_EMPTY || (n == 0 && close_how != CLOSE_NONE)) begin
         w.char_code = 8'($urandom_range(0, 255));
         w.has_char  = 1'b0;
         w.last      = 1'b1;
         word_q.push_back(w);
         in_flight++;
         items_queued++;
      end
      text_buf.delete();
   endfunction

   function automatic void send_text(input string s, input int close_how);
      put_str(s);
      flush_text(close_how, 1'b0);
   endfunction

   // Mostly well-formed angles with random content, some broken, some junk
   function automatic void build_random_string(input bit hp);
      int kind, deg, mins, secs, n_min, n_sec, k;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         k = $urandom_range(0, 10);
         repeat (k) put_byte(pick_char());
         return;
      end
      put_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      k = $urandom_range(0, 99);
      deg = (k < 12) ? 90 : (k < 18) ? $urandom_range(91, 99) :
            (k < 24) ? 0 : $urandom_range(0, 89);
      put_digits(deg, 2);
      put_byte(CH_STAR);
      k = $urandom_range(0, 99);
      n_min = (k < 80) ? 2 : (k < 88) ? 1 : (k < 96) ? 3 : $urandom_range(0, 5);
      mins = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(60, 999);
      secs = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(60, 99);
      if (deg == 90 && $urandom_range(0, 1)) begin
         mins = 0;
         secs = 0;
      end
      put_digits(mins, n_min);
      // now and then the other form from the one selected
      if (hp != ($urandom_range(0, 9) == 0)) begin
         put_byte($urandom_range(0, 1) ? CH_COLON : CH_APOS);
         n_sec = ($urandom_range(0, 99) < 85) ? 2 : $urandom_range(0, 3);
         put_digits(secs, n_sec);
      end
      if (kind < 30) begin
         k = $urandom_range(0, text_buf.size() - 1);
         case ($urandom_range(0, 2))
            0:       text_buf[k] = pick_char();
            1:       void'(text_buf.pop_back());
            default: put_byte(pick_char());
         endcase
      end
   endfunction

   // Hold off until every word is through and every angle has come back
   task automatic wait_idle();
      do
         @(posedge clock);
      while (in_flight != 0 || parsed_angle_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit hp);
      wait_idle();
      csr_valid          <= 1'b1;
      csr_high_precision <= hp;
      do
         @(posedge clock);
      while (!csr_ready);
      cfg_hp = hp;
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      fail_cnt++;
      $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : driver
      item_type w;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            decl_parse_word(drive_word);
            in_flight--;
            if ($urandom_range(0, 99) == 0)
               drv_calm = !drv_calm;
         end
         // a held word stays put while stalled
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (word_q.size() != 0) begin
               w = word_q.pop_front();
               drive_word = w;
               req_char_code <= w.char_code;
               req_has_char  <= w.has_char;
               req_last      <= w.last;
               req_valid     <= 1'b1;
               gap_left = drv_calm ? 0 : pick_pause();
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      result_type want;
      int         n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (parsed_angle_q.size() == 0)
               report_mismatch("unexpected result, status", 8'(rsp_status), 8'd0);
            else begin
               want = parsed_angle_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 8'(rsp_status), 8'(want.status));
               if (rsp_negative !== want.negative)
                  report_mismatch("negative", 8'(rsp_negative), 8'(want.negative));
               if (rsp_deg_out !== want.deg)
                  report_mismatch("deg_out", 8'(rsp_deg_out), 8'(want.deg));
               if (rsp_arcmin_out !== want.arcmin)
                  report_mismatch("arcmin_out", 8'(rsp_arcmin_out), 8'(want.arcmin));
               if (rsp_arcsec_out !== want.arcsec)
                  report_mismatch("arcsec_out", 8'(rsp_arcsec_out), 8'(want.arcsec));
            end
            if ($urandom_range(0, 99) == 0)
               mon_calm = !mon_calm;
         end
         // a new stall run starts only after rsp_stall has dropped
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            n = (mon_calm || rsp_stall) ? 0 : pick_pause();
            rsp_stall <= (n != 0);
            stall_left = (n > 0) ? n - 1 : 0;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("** declination_string_parser_unit: FAILED **");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      int goal;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, seconds form selected from reset
      send_text("+00*00:00", CLOSE_ON_CHAR);
      send_text("-90*00'00", CLOSE_ON_CHAR);
      send_text("+90*00:01", CLOSE_ON_CHAR);
      send_text("+89*59:59", CLOSE_ON_CHAR);
      send_text("-91*00:00", CLOSE_ON_CHAR);
      flush_text(CLOSE_EMPTY, 1'b0);                // empty string
      put_str("+1");
      put_byte(8'h00);                              // NUL among the degrees
      send_text("*00:00", CLOSE_ON_CHAR);
      send_text("+12*60:00", CLOSE_ON_CHAR);
      send_text("+12*5'7", CLOSE_ON_CHAR);
      send_text("+12*:30", CLOSE_ON_CHAR);
      send_text("+12*123456:00", CLOSE_ON_CHAR);    // minutes clamp
      put_byte(8'hFF);
      send_text("12*00:00", CLOSE_ON_CHAR);
      send_text("+45*30", CLOSE_ON_CHAR);
      put_str("+45*30:00");
      flush_text(CLOSE_EMPTY, 1'b1);
      send_text("+12*05:123", CLOSE_ON_CHAR);

      // Directed, minutes-only form
      write_mode(1'b0);
      send_text("+45*30", CLOSE_ON_CHAR);
      send_text("-90*00", CLOSE_ON_CHAR);
      send_text("+90*01", CLOSE_ON_CHAR);
      send_text("+45*3", CLOSE_ON_CHAR);
      send_text("+45*30:00", CLOSE_ON_CHAR);
      send_text("+45*60", CLOSE_ON_CHAR);
      send_text("+45*305", CLOSE_ON_CHAR);

      // Mode flipped half way through a string: the latched mode still rules
      send_text("+10*", CLOSE_NONE);
      write_mode(1'b1);
      send_text("20", CLOSE_ON_CHAR);
      send_text("+10*20", CLOSE_ON_CHAR);

      // Random phases, each behind a drain and a mode write
      for (int p = 0; p < 10; p++) begin
         write_mode((p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
         if (p == 0) begin
            // one very long minutes field, past the position counter's top
            put_str("+10*");
            repeat (270) put_byte(CH_NINE);
            send_text(":00", CLOSE_ON_CHAR);
         end
         goal = items_queued + PHASE_WORDS;
         while (items_queued < goal) begin
            build_random_string(cfg_hp);
            flush_text(($urandom_range(0, 99) < 15) ? CLOSE_EMPTY : CLOSE_ON_CHAR,
                       $urandom_range(0, 3) == 0);
         end
      end

      wait_idle();
      if (fail_cnt == 0)
         $display("** declination_string_parser_unit: PASSED **");
      else
         $display("** declination_string_parser_unit: FAILED **");
      $finish;
   end

endmodule

>>> declination_string_parser_unit.f
hw/rtl/dsp_pkg.sv
hw/rtl/dsp_input_stage.sv
hw/rtl/dsp_parse_core.sv
hw/rtl/declination_string_parser_unit.sv
hw/rtl/dsp_checker.sv
test/declination_string_parser_unit_tb.sv
